>>> rtl/acrms_pkg.sv
package acrms_pkg;

   // Field and datapath widths.
   localparam int SAMPLE_W  = 12;
   localparam int OFFSET_W  = SAMPLE_W + 4;
   localparam int PLAIN_W   = 20;
   localparam int SQUARE_W  = 40;
   localparam int COUNT_W   = 13;
   localparam int GAIN_W    = 24;
   localparam int FLOOR_W   = 20;
   localparam int VALUE_W   = 20;
   localparam int DIV_W     = SQUARE_W;
   localparam int ROOT_W    = DIV_W / 2;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 1;

   // Defaults and reset values.
   localparam int MAX_SAMPLES_DEF = 256;
   localparam int QUEUE_DEPTH     = 2;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(1) << (OFFSET_W - 1);
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = GAIN_W'(28548);
   localparam logic [FLOOR_W-1:0]  FLOOR_RESET  = FLOOR_W'(5);

   // Window kinds, as carried by req_type and rsp_result_kind.
   localparam logic KIND_CAL  = 1'b0;
   localparam logic KIND_MEAS = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR = 1'b1;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_ACC,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV,
      B_SQRT,
      B_MUL,
      B_ROUND,
      B_DONE
   } back_state_type;

   // One closed window, handed from the accumulator to the math unit.
   typedef struct packed {
      logic                kind;
      logic [PLAIN_W-1:0]  plain;
      logic [SQUARE_W-1:0] square;
      logic [COUNT_W-1:0]  count;
      logic                overflow;
   } win_rec_type;

   // New zero offset, sent back to the accumulator.
   typedef struct packed {
      logic                valid;
      logic [OFFSET_W-1:0] value;
   } offset_upd_type;

endpackage

>>> rtl/acrms_front.sv
module acrms_front import acrms_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic                req_window_last,
   input  logic                queue_full,
   output logic                push,
   output win_rec_type         push_rec,
   input  offset_upd_type      offset_upd
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

   front_state_type state_ff, state_in;

   logic                  cal_wait_ff, cal_wait_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [PLAIN_W-1:0]    plain_ff, plain_in;
   logic [SQUARE_W-1:0]   square_ff, square_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;

   logic                  kind_ff, kind_in;
   logic                  last_ff, last_in;
   logic                  take_ff, take_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic [OFFSET_W-1:0]   mag_ff, mag_in;
   logic [2*OFFSET_W-1:0] sq_ff, sq_in;

   logic                  accept;
   logic [OFFSET_W-1:0]   s16;
   logic [PLAIN_W:0]      plain_sum;
   logic [SQUARE_W:0]     square_sum;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (accept) state_in = F_MUL;
         F_MUL:  state_in = F_ACC;
         F_ACC:  state_in = last_ff ? F_PUSH : F_IDLE;
         F_PUSH: if (!queue_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      push      = 1'b0;
      unique case (state_ff)
         F_IDLE:  req_stall = cal_wait_ff;
         F_PUSH:  push = !queue_full;
         default: ;
      endcase
   end

   assign accept = req_valid && !req_stall;

   assign push_rec.kind     = kind_ff;
   assign push_rec.plain    = plain_ff;
   assign push_rec.square   = square_ff;
   assign push_rec.count    = COUNT_W'(count_ff);
   assign push_rec.overflow = ovf_ff;

   // Offset removal happens on the way in, so the multiplier sees a magnitude.
   assign s16        = {req_sample, 4'b0000};
   assign plain_sum  = {1'b0, plain_ff} + (PLAIN_W + 1)'(sample_ff);
   assign square_sum = {1'b0, square_ff} + (SQUARE_W + 1)'(sq_ff);

   always_comb begin
      kind_in   = kind_ff;
      last_in   = last_ff;
      take_in   = take_ff;
      sample_in = sample_ff;
      mag_in    = mag_ff;
      sq_in     = sq_ff;
      plain_in  = plain_ff;
      square_in = square_ff;
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      offset_in = offset_ff;
      cal_wait_in = cal_wait_ff;

      if (accept) begin
         kind_in   = req_type;
         last_in   = req_window_last;
         take_in   = count_ff < MAX_CNT;
         sample_in = req_sample;
         mag_in    = (s16 >= offset_ff) ? s16 - offset_ff : offset_ff - s16;
      end

      if (state_ff == F_MUL) begin
         sq_in = mag_ff * mag_ff;
         if (take_ff) begin
            plain_in = plain_sum[PLAIN_W] ? {PLAIN_W{1'b1}} : plain_sum[PLAIN_W-1:0];
         end
      end

      if (state_ff == F_ACC) begin
         if (take_ff) begin
            square_in = square_sum[SQUARE_W] ? {SQUARE_W{1'b1}} : square_sum[SQUARE_W-1:0];
            count_in  = count_ff + 1'b1;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (offset_upd.valid) begin
         offset_in   = offset_upd.value;
         cal_wait_in = 1'b0;
      end

      if (push) begin
         plain_in  = '0;
         square_in = '0;
         count_in  = '0;
         ovf_in    = 1'b0;
         if (kind_ff == KIND_CAL) cal_wait_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         cal_wait_ff <= 1'b0;
         offset_ff   <= OFFSET_RESET;
         plain_ff    <= '0;
         square_ff   <= '0;
         count_ff    <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cal_wait_ff <= cal_wait_in;
         offset_ff   <= offset_in;
         plain_ff    <= plain_in;
         square_ff   <= square_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      last_ff   <= last_in;
      take_ff   <= take_in;
      sample_ff <= sample_in;
      mag_ff    <= mag_in;
      sq_ff     <= sq_in;
   end

   // No sample may enter while a calibration result is still on its way back.
   assert property (@(posedge clock) disable iff (reset) cal_wait_ff |-> req_stall)
      else $error("front accepted a request during a pending calibration");

   // The count never passes the window limit.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MAX_CNT)
      else $error("sample count beyond the window limit");

endmodule

>>> rtl/acrms_queue.sv
module acrms_queue import acrms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  win_rec_type push_rec,
   output logic        full,
   input  logic        pop,
   output win_rec_type pop_rec,
   output logic        empty
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [FILL_W-1:0] DEPTH    = FILL_W'(QUEUE_DEPTH);

   win_rec_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;

   assign full    = fill_ff == DEPTH;
   assign empty   = fill_ff == '0;
   assign pop_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      fill_in = fill_ff + 1'b1;
      else if (pop && !push) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_rec;
   end

   // Neither side may act past the ends of the queue.
   assert property (@(posedge clock) disable iff (reset) !(push && full) && !(pop && empty))
      else $error("queue pushed when full or popped when empty");

endmodule

>>> rtl/acrms_back.sv
module acrms_back import acrms_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  win_rec_type         head_rec,
   output logic                pop,
   input  logic [GAIN_W-1:0]   rms_gain,
   input  logic [FLOOR_W-1:0]  noise_floor,
   output offset_upd_type      offset_upd,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_result_kind,
   output logic [VALUE_W-1:0]  rsp_value,
   output logic                rsp_below_floor,
   output logic                rsp_window_overflow
);

   localparam int STEP_W = $clog2(DIV_W);
   localparam int CAL_W  = PLAIN_W + 5;
   localparam int PROD_W = ROOT_W + GAIN_W;
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(DIV_W - 1);
   localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
   localparam logic [PROD_W:0]   HALF_LSB  = (PROD_W + 1)'(1) << (VALUE_W - 1);

   back_state_type state_ff, state_in;

   logic                 kind_ff, kind_in;
   logic                 ovf_ff, ovf_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic [DIV_W-1:0]     work_ff, work_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [ROOT_W+1:0]    sqrem_ff, sqrem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [VALUE_W-1:0]   val_ff, val_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_below_ff, rsp_below_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   logic                 load;
   logic                 out_free;
   logic [COUNT_W-1:0]   head_n;
   logic [CAL_W-1:0]     cal_dividend;
   logic [COUNT_W:0]     rem_sh;
   logic                 div_ge;
   logic [ROOT_W+3:0]    sq_t;
   logic [ROOT_W+3:0]    sq_trial;
   logic                 sq_ge;
   logic [PROD_W:0]      rounded;
   logic [PROD_W-VALUE_W:0] scaled;
   logic                 below;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:  if (!queue_empty) state_in = B_DIV;
         B_DIV:   if (step_ff == DIV_LAST) state_in = (kind_ff == KIND_CAL) ? B_DONE : B_SQRT;
         B_SQRT:  if (step_ff == SQRT_LAST) state_in = B_MUL;
         B_MUL:   state_in = B_ROUND;
         B_ROUND: state_in = B_DONE;
         B_DONE:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      pop  = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         B_IDLE:  pop = !queue_empty;
         B_DONE:  load = out_free;
         default: ;
      endcase
   end

   // A window always has at least one sample; the guard keeps the divider sane.
   assign head_n       = (head_rec.count == '0) ? COUNT_W'(1) : head_rec.count;
   assign cal_dividend = CAL_W'({head_rec.plain, 4'b0000}) + CAL_W'(head_n >> 1);

   // Restoring divider, one quotient bit per cycle.
   assign rem_sh = {rem_ff, work_ff[DIV_W-1]};
   assign div_ge = rem_sh >= {1'b0, n_ff};

   // Digit-by-digit square root, two radicand bits per cycle.
   assign sq_t     = {sqrem_ff, work_ff[DIV_W-1:DIV_W-2]};
   assign sq_trial = {2'b00, root_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;

   assign rounded = {1'b0, prod_ff} + HALF_LSB;
   assign scaled  = rounded[PROD_W:VALUE_W];
   assign below   = (kind_ff == KIND_MEAS) && (val_ff < noise_floor);

   always_comb begin
      kind_in  = kind_ff;
      ovf_in   = ovf_ff;
      n_in     = n_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      sqrem_in = sqrem_ff;
      root_in  = root_ff;
      prod_in  = prod_ff;
      val_in   = val_ff;
      unique case (state_ff)
         B_IDLE: begin
            kind_in = head_rec.kind;
            ovf_in  = head_rec.overflow;
            n_in    = head_n;
            work_in = (head_rec.kind == KIND_CAL) ? DIV_W'(cal_dividend) : head_rec.square;
            rem_in  = '0;
            step_in = '0;
         end
         B_DIV: begin
            rem_in  = div_ge ? COUNT_W'(rem_sh - {1'b0, n_ff}) : COUNT_W'(rem_sh);
            work_in = {work_ff[DIV_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               step_in  = '0;
               sqrem_in = '0;
               root_in  = '0;
               val_in   = VALUE_W'(work_in[OFFSET_W-1:0]);
            end
         end
         B_SQRT: begin
            sqrem_in = sq_ge ? (ROOT_W + 2)'(sq_t - sq_trial) : (ROOT_W + 2)'(sq_t);
            root_in  = {root_ff[ROOT_W-2:0], sq_ge};
            work_in  = {work_ff[DIV_W-3:0], 2'b00};
            step_in  = step_ff + 1'b1;
         end
         B_MUL: prod_in = root_ff * rms_gain;
         B_ROUND: begin
            val_in = (scaled > (PROD_W - VALUE_W + 1)'({VALUE_W{1'b1}})) ?
                     {VALUE_W{1'b1}} : scaled[VALUE_W-1:0];
         end
         B_DONE: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_below_in = rsp_below_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = kind_ff;
         rsp_value_in = below ? '0 : val_ff;
         rsp_below_in = below;
         rsp_ovf_in   = ovf_ff;
      end
   end

   assign offset_upd.valid = load && (kind_ff == KIND_CAL);
   assign offset_upd.value = val_ff[OFFSET_W-1:0];

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = rsp_kind_ff;
   assign rsp_value           = rsp_value_ff;
   assign rsp_below_floor     = rsp_below_ff;
   assign rsp_window_overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      ovf_ff       <= ovf_in;
      n_ff         <= n_in;
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      sqrem_ff     <= sqrem_in;
      root_ff      <= root_in;
      prod_ff      <= prod_in;
      val_ff       <= val_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_below_ff <= rsp_below_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // An offset result never carries the floor flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_CAL) |-> !rsp_below_ff)
      else $error("offset result flagged below floor");

   // A new result only enters the output register once the old one has left.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(rsp_value_ff) && rsp_valid_ff)
      else $error("pending result overwritten");

endmodule

>>> rtl/ac_true_rms_meter_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_type, req_sample, req_window_last
// rsp       out        rsp_valid / rsp_stall  rsp_result_kind, rsp_value,
//                                             rsp_below_floor, rsp_window_overflow
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// The accumulator takes a new request only once the last has passed its multiply
// and accumulate states; a request that closes a window then waits in a push state
// until the queue has room. Per window the math unit runs its restoring divider, then
// for a measurement the square root, gain and rounding steps, and loads the result.
// After a calibration window no request is taken until the new offset is stored.
// Reset is synchronous; it restores the register defaults and a mid-scale offset.
// A stalled result waits in the output register while the next windows proceed.
module ac_true_rms_meter_top import acrms_pkg::*; #(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_type,
   input  logic [SAMPLE_W-1:0]  req_sample,
   input  logic                 req_window_last,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_result_kind,
   output logic [VALUE_W-1:0]   rsp_value,
   output logic                 rsp_below_floor,
   output logic                 rsp_window_overflow,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   // Configuration registers. The user must write them only while the block is idle; the block does not enforce this.
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [FLOOR_W-1:0] floor_ff, floor_in;

   win_rec_type    push_rec;
   win_rec_type    head_rec;
   logic           push;
   logic           pop;
   logic           queue_full;
   logic           queue_empty;
   offset_upd_type offset_upd;

   always_comb begin
      gain_in  = gain_ff;
      floor_in = floor_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_GAIN:  gain_in  = csr_write_data[GAIN_W-1:0];
            CSR_FLOOR: floor_in = csr_write_data[FLOOR_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         floor_ff <= FLOOR_RESET;
      end else begin
         gain_ff  <= gain_in;
         floor_ff <= floor_in;
      end
   end

   // The front end removes the offset, squares and accumulates each sample,
   // and closes a window into a single record.
   acrms_front #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_sample     (req_sample),
      .req_window_last(req_window_last),
      .queue_full     (queue_full),
      .push           (push),
      .push_rec       (push_rec),
      .offset_upd     (offset_upd)
   );

   // Closed windows wait here, so sampling continues while the math unit works.
   acrms_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_rec(push_rec),
      .full    (queue_full),
      .pop     (pop),
      .pop_rec (head_rec),
      .empty   (queue_empty)
   );

   // The back end divides by the sample count, then either returns the new
   // offset or takes the square root, applies the gain and checks the floor.
   acrms_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (queue_empty),
      .head_rec           (head_rec),
      .pop                (pop),
      .rms_gain           (gain_ff),
      .noise_floor        (floor_ff),
      .offset_upd         (offset_upd),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_value          (rsp_value),
      .rsp_below_floor    (rsp_below_floor),
      .rsp_window_overflow(rsp_window_overflow)
   );

endmodule
